// File: hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int SENDER_W = 32;
  localparam int SEQ_W    = 16;
  localparam int WIN_W    = 8;

  localparam logic [WIN_W-1:0] WIN_RESET = 8'd8;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
  } entry_t;

endpackage

// File: hw/rtl/sdf_if.sv
`timescale 1ns / 1ps

interface sdf_in_if;
  import sdf_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SENDER_W-1:0] sender;
  logic [SEQ_W-1:0]    seq_num;
  modport source (output valid, cmd, sender, seq_num, input ready);
  modport sink   (input valid, cmd, sender, seq_num, output ready);
endinterface

interface sdf_out_if;
  logic valid;
  logic ready;
  logic is_new;
  logic sender_found;
  logic table_full;
  modport source (output valid, is_new, sender_found, table_full, input ready);
  modport sink   (input valid, is_new, sender_found, table_full, output ready);
endinterface

interface sdf_cfg_if;
  import sdf_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] loss_window;
  modport source (output valid, loss_window, input ready);
  modport sink   (input valid, loss_window, output ready);
endinterface

// File: hw/rtl/sequence_duplicate_filter.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                               Handshake
// in_ch    in   cmd, sender[31:0], seq_num[15:0]      valid/ready
// out_ch   out  is_new, sender_found, table_full      valid/ready
// cfg_ch   in   loss_window[7:0]                      valid/ready, always ready
// A request scans the table until its first hit or the last slot: the table memory's
// single read port walks one slot per cycle.
// Result waits in an output register; the next request is taken while it waits.
// A stalled result holds the write-back step until out_ch drains.
// Reset empties the table through per-slot valid flops; no clearing pass.
module sequence_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input logic  clk,
  input logic  rst_n,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch,
  sdf_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  state_t state_r, state_nxt;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [WIN_W-1:0]       window_r;

  logic                cmd_r;
  logic [SENDER_W-1:0] sender_r;
  logic [SEQ_W-1:0]    seq_r;

  logic [CNT_W-1:0] iss_cnt_r;
  logic             cmp_v_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [SEQ_W-1:0] hit_seq_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  logic out_valid_r, is_new_r, found_r, full_r;

  logic             in_acc, issue, slot_v, match, finish;
  logic [IDX_W-1:0] rd_addr;
  logic [WIN_W-1:0] ahead;
  logic             newer, out_free;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_new       = is_new_r;
  assign out_ch.sender_found = found_r;
  assign out_ch.table_full   = full_r;
  assign out_free            = !out_valid_r || out_ch.ready;

  assign rd_addr = iss_cnt_r[IDX_W-1:0];
  assign issue   = (state_r == ST_SCAN) && (iss_cnt_r < CNT_W'(TABLE_DEPTH));
  assign slot_v  = valid_r[cmp_idx_r];
  assign match   = cmp_v_r && slot_v && (rd_data_r.sender == sender_r);
  assign finish  = cmp_v_r && (match || cmp_idx_r == LAST_IDX);

  assign ahead = WIN_W'(seq_r - hit_seq_r);
  assign newer = (seq_r != hit_seq_r) && (ahead != '0) && (ahead <= window_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (finish) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
    end else if (cfg_ch.valid) begin
      window_r <= cfg_ch.loss_window;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.cmd;
      sender_r <= in_ch.sender;
      seq_r    <= in_ch.seq_num;
    end
  end

  // table memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
    if (state_r == ST_DONE && out_free && cmd_r == CMD_ADD) begin
      if (hit_r) begin
        if (newer) begin
          mem[hit_idx_r] <= '{sender: sender_r, seq: seq_r};
        end
      end else if (free_r) begin
        mem[free_idx_r] <= '{sender: sender_r, seq: seq_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r <= '0;
      cmp_v_r   <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else if (in_acc) begin
      iss_cnt_r <= '0;
      cmp_v_r   <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      cmp_v_r <= issue && !finish;
      if (issue) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (match) begin
        hit_r <= 1'b1;
      end else if (cmp_v_r && !slot_v && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx_r <= rd_addr;
    end
    if (match) begin
      hit_idx_r <= cmp_idx_r;
      hit_seq_r <= rd_data_r.seq;
    end
    if (state_r == ST_SCAN && cmp_v_r && !slot_v && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (cmd_r == CMD_REMOVE) begin
          if (hit_r) valid_r[hit_idx_r] <= 1'b0;
        end else if (!hit_r && free_r) begin
          valid_r[free_idx_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      found_r <= hit_r;
      if (cmd_r == CMD_REMOVE) begin
        is_new_r <= 1'b0;
        full_r   <= 1'b0;
      end else begin
        is_new_r <= hit_r ? newer : 1'b1;
        full_r   <= !hit_r && !free_r;
      end
    end
  end

  a_full_means_new_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && full_r |-> is_new_r && !found_r)
    else $error("table_full with known sender or not new");

  a_full_only_when_table_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !hit_r && !free_r |-> valid_r == '1)
    else $error("no free slot found while table has a free slot");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> iss_cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("scan counter ran past table depth");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SCAN && iss_cnt_r == '0 && !hit_r)
    else $error("request did not start a fresh scan");

endmodule
